@@ rtl/slim_pkg.sv @@
`default_nettype none
package slim_pkg;
   localparam int SAMPLE_BITS      = 24;
   localparam int FRAME_COUNT_BITS = 16;
   localparam int GAIN_BITS        = 24;
   localparam int MODE_BITS        = 2;
   localparam int BUDGET_BITS      = 48;
   localparam int RATE_BITS        = 24;
   localparam int CSR_DATA_BITS    = 48;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int MEAN_BITS        = 48;
   localparam int CUR_BITS         = 40;
   localparam int STEP_BITS        = 41;
   localparam int RATIO_BITS       = 46;
   localparam int ROOT_STEPS       = RATIO_BITS / 2;
   localparam int CNT_BITS         = $clog2(RATIO_BITS + 1);

   localparam logic [MODE_BITS-1:0] MODE_BLOCK  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_BUDGET  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DETECTOR_RATE = 1'b1;

   localparam logic [GAIN_BITS-1:0]   UNITY_GAIN   = 24'h800000;
   localparam logic [CUR_BITS-1:0]    UNITY_CUR    = 40'h80_0000_0000;
   localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 48'h8000_0000_0000;
endpackage
`default_nettype wire

@@ rtl/slim_if.sv @@
`default_nettype none
interface slim_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [slim_pkg::MODE_BITS-1:0]           mode;
   logic [slim_pkg::FRAME_COUNT_BITS-1:0]    frame_count;
   logic signed [slim_pkg::SAMPLE_BITS-1:0]  woofer_sample;
   logic signed [slim_pkg::SAMPLE_BITS-1:0]  tweeter_sample;
   modport source (output valid, mode, frame_count, woofer_sample, tweeter_sample,
                   input ready);
   modport sink   (input valid, mode, frame_count, woofer_sample, tweeter_sample,
                   output ready);
endinterface

interface slim_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [slim_pkg::GAIN_BITS-1:0]   gain;
   modport source (output valid, gain, input ready);
   modport sink   (input valid, gain, output ready);
endinterface
`default_nettype wire

@@ rtl/supply_power_limiter.sv @@
// sample beat: bit-serial square over the sample bits, then bit-serial
//   detector multiply over the rate bits, then round, update and output register
// block begin: a 46-step restoring divider, 23-step root and 41-step frame divider;
//   a mean within budget skips divider and root; clear and unused beats stay idle
// one beat at a time; a waiting result holds only a sample beat's output step
// reset (synchronous, active high) clears detector, sets gain to unity, budget 2^47, rate 0
`default_nettype none
module supply_power_limiter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   slim_req_if.sink                                   req_ch,
   slim_rsp_if.source                                 rsp_ch,
   input  wire logic                                  csr_we,
   input  wire logic [slim_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [slim_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   localparam int SB     = slim_pkg::SAMPLE_BITS;
   localparam int FB     = slim_pkg::FRAME_COUNT_BITS;
   localparam int SQ_W   = 2 * SB + 1;
   localparam int PSHIFT = 46 - 2 * (SB - 1);
   localparam int SHL    = (PSHIFT >= 0) ? PSHIFT : 0;
   localparam int SHR    = (PSHIFT < 0) ? -PSHIFT : 0;
   localparam int CW     = slim_pkg::CNT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_PWR, ST_MAC, ST_ROUND, ST_UPD, ST_OUT,
      ST_DIV, ST_SQRT, ST_STEP, ST_FDIV, ST_SIGN
   } state_type;

   state_type                     state_ff;
   logic [CW-1:0]                 cnt_ff;
   logic [SB-1:0]                 a_ff, b_ff, a_sr_ff, b_sr_ff;
   logic [SQ_W-1:0]               sq_ff;
   logic [47:0]                   mag_ff;
   logic                          up_ff;
   logic [23:0]                   rate_sr_ff;
   logic [71:0]                   prod_ff;
   logic [47:0]                   mean_ff, budget_ff;
   logic [23:0]                   rate_ff;
   logic [39:0]                   cur_ff;
   logic [23:0]                   tgt_ff;
   logic signed [40:0]            step_ff;
   logic [FB-1:0]                 frames_ff;
   logic [48:0]                   r_ff;
   logic [45:0]                   q_ff;
   logic [24:0]                   rem_ff;
   logic [23:0]                   root_ff;
   logic [40:0]                   div_ff;
   logic [FB-1:0]                 drem_ff;
   logic                          neg_ff;
   logic [23:0]                   out_ff, gain_ff;
   logic                          rsp_valid_ff;

   logic                          accept;
   logic [SB-1:0]                 wmag, tmag;
   logic [SB+1:0]                 sq_top;
   logic [SQ_W-1:0]               sq_in;
   logic [47:0]                   pwr;
   logic [48:0]                   mac_top;
   logic [71:0]                   prod_in;
   logic [47:0]                   inc_in;
   logic [48:0]                   r_sh;
   logic [48:0]                   r_in;
   logic [45:0]                   q_in;
   logic [26:0]                   rm, trial;
   logic [24:0]                   rem_in;
   logic [23:0]                   root_in;
   logic signed [40:0]            diff;
   logic [FB:0]                   dr;
   logic [FB-1:0]                 drem_in;
   logic [40:0]                   div_in;
   logic signed [41:0]            g0, gs, tg;
   logic [39:0]                   cur_in;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.gain   = gain_ff;

   assign wmag = req_ch.woofer_sample[SB-1] ? SB'(-req_ch.woofer_sample)
                                            : SB'(req_ch.woofer_sample);
   assign tmag = req_ch.tweeter_sample[SB-1] ? SB'(-req_ch.tweeter_sample)
                                             : SB'(req_ch.tweeter_sample);

   always_comb begin
      sq_top  = {1'b0, sq_ff[SQ_W-1:SB]} + (a_sr_ff[0] ? {2'b0, a_ff} : '0)
                + (b_sr_ff[0] ? {2'b0, b_ff} : '0);
      sq_in   = SQ_W'({sq_top, sq_ff[SB-1:1]});
      pwr     = 48'((({48'd0, sq_ff}) << SHL) >> SHR);
      mac_top = {1'b0, prod_ff[71:24]} + (rate_sr_ff[0] ? {1'b0, mag_ff} : 49'd0);
      prod_in = {mac_top, prod_ff[23:1]};
      inc_in  = 48'((prod_ff + 72'h80_0000) >> 24);

      r_sh = {r_ff[47:0], 1'b0};
      if (r_sh >= {1'b0, mean_ff}) begin
         r_in = r_sh - {1'b0, mean_ff};
         q_in = {q_ff[44:0], 1'b1};
      end else begin
         r_in = r_sh;
         q_in = {q_ff[44:0], 1'b0};
      end

      rm    = {rem_ff, q_ff[45:44]};
      trial = {1'b0, root_ff, 2'b01};
      if (rm >= trial) begin
         rem_in  = 25'(rm - trial);
         root_in = {root_ff[22:0], 1'b1};
      end else begin
         rem_in  = 25'(rm);
         root_in = {root_ff[22:0], 1'b0};
      end

      diff = $signed({1'b0, tgt_ff, 16'd0}) - $signed({1'b0, cur_ff});
      dr   = {drem_ff, div_ff[40]};
      if (dr >= {1'b0, frames_ff}) begin
         drem_in = FB'(dr - {1'b0, frames_ff});
         div_in  = {div_ff[39:0], 1'b1};
      end else begin
         drem_in = FB'(dr);
         div_in  = {div_ff[39:0], 1'b0};
      end

      g0 = $signed({2'b0, cur_ff});
      tg = $signed({2'b0, tgt_ff, 16'd0});
      gs = g0 + 42'(step_ff);
      if (step_ff > 0 && gs > tg) begin
         gs = tg;
      end else if (step_ff < 0 && gs < tg) begin
         gs = tg;
      end
      if (gs < 0) begin
         cur_in = '0;
      end else if (gs > $signed({2'b0, slim_pkg::UNITY_CUR})) begin
         cur_in = slim_pkg::UNITY_CUR;
      end else begin
         cur_in = gs[39:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mean_ff      <= '0;
         cur_ff       <= slim_pkg::UNITY_CUR;
         tgt_ff       <= slim_pkg::UNITY_GAIN;
         step_ff      <= '0;
         budget_ff    <= slim_pkg::BUDGET_RESET;
         rate_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               slim_pkg::CSR_POWER_BUDGET:  budget_ff <= csr_data[47:0];
               slim_pkg::CSR_DETECTOR_RATE: rate_ff   <= csr_data[23:0];
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_ch.mode)
                     slim_pkg::MODE_SAMPLE: begin
                        if (rate_ff == '0) begin
                           out_ff   <= slim_pkg::UNITY_GAIN;
                           state_ff <= ST_OUT;
                        end else begin
                           a_ff     <= wmag;
                           a_sr_ff  <= wmag;
                           b_ff     <= tmag;
                           b_sr_ff  <= tmag;
                           sq_ff    <= '0;
                           cnt_ff   <= CW'(SB);
                           state_ff <= ST_SQ;
                        end
                     end
                     slim_pkg::MODE_BLOCK: begin
                        frames_ff <= req_ch.frame_count;
                        if (rate_ff != '0) begin
                           if (mean_ff <= budget_ff) begin
                              tgt_ff   <= slim_pkg::UNITY_GAIN;
                              state_ff <= ST_STEP;
                           end else begin
                              r_ff     <= {1'b0, budget_ff};
                              q_ff     <= '0;
                              cnt_ff   <= CW'(slim_pkg::RATIO_BITS);
                              state_ff <= ST_DIV;
                           end
                        end
                     end
                     slim_pkg::MODE_CLEAR: begin
                        mean_ff <= '0;
                        cur_ff  <= slim_pkg::UNITY_CUR;
                        tgt_ff  <= slim_pkg::UNITY_GAIN;
                        step_ff <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SQ: begin
               sq_ff   <= sq_in;
               a_sr_ff <= a_sr_ff >> 1;
               b_sr_ff <= b_sr_ff >> 1;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= ST_PWR;
               end
            end
            ST_PWR: begin
               up_ff      <= (pwr >= mean_ff);
               mag_ff     <= (pwr >= mean_ff) ? pwr - mean_ff : mean_ff - pwr;
               rate_sr_ff <= rate_ff;
               prod_ff    <= '0;
               cnt_ff     <= CW'(24);
               state_ff   <= ST_MAC;
            end
            ST_MAC: begin
               prod_ff    <= prod_in;
               rate_sr_ff <= rate_sr_ff >> 1;
               cnt_ff     <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               mag_ff   <= inc_in;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               mean_ff  <= up_ff ? mean_ff + mag_ff : mean_ff - mag_ff;
               cur_ff   <= cur_in;
               out_ff   <= cur_in[39:16];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  gain_ff      <= out_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_DIV: begin
               r_ff   <= r_in;
               q_ff   <= q_in;
               if (cnt_ff == CW'(1)) begin
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CW'(slim_pkg::ROOT_STEPS);
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_SQRT: begin
               rem_ff  <= rem_in;
               root_ff <= root_in;
               q_ff    <= {q_ff[43:0], 2'b00};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  tgt_ff   <= root_in;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (frames_ff == '0) begin
                  step_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  neg_ff   <= diff[40];
                  div_ff   <= diff[40] ? 41'(-diff) : 41'(diff);
                  drem_ff  <= '0;
                  cnt_ff   <= CW'(41);
                  state_ff <= ST_FDIV;
               end
            end
            ST_FDIV: begin
               drem_ff <= drem_in;
               div_ff  <= div_in;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               step_ff  <= neg_ff ? -$signed(div_ff) : $signed(div_ff);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/slim_checker.sv @@
`default_nettype none
module slim_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [slim_pkg::GAIN_BITS-1:0]     rsp_gain
);
   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gain))
      else $error("result beat dropped or changed while stalled");

   // gain never exceeds unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= slim_pkg::UNITY_GAIN)
      else $error("gain above unity");

   // a new result beat is launched while the input is closed
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result launched in the cycle of an input beat");
endmodule

bind supply_power_limiter slim_checker u_slim_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_gain  (rsp_ch.gain)
);
`default_nettype wire
